FILE: sv/riscv_instruction_encoder_core_defines.svh
// Assertion macros shared by the instruction encoder RTL.
`ifndef RISCV_INSTRUCTION_ENCODER_CORE_DEFINES_SVH
`define RISCV_INSTRUCTION_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RIE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is high.
`define RIE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

FILE: sv/rie_pkg.sv
// Package with the instruction encoder's types, opcode constants and decode table.
package rie_pkg;

  localparam int unsigned CODE_W    = 7;
  localparam int unsigned REG_W     = 5;
  localparam int unsigned IMM_W     = 20;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned ERR_W     = 2;
  localparam int unsigned NUM_CODES = 74;

  localparam logic [ADDR_W-1:0] PC_RESET = '0;
  localparam logic [ADDR_W-1:0] WORD_BYTES = 32'd4;

  // Error codes carried with every result transaction.
  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE     = 2'd1;
  localparam logic [ERR_W-1:0] ERR_UNKNOWN   = 2'd2;
  localparam logic [ERR_W-1:0] ERR_NEG_SHIFT = 2'd3;

  // Major opcodes.
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_REG    = 7'b0110011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_REG32  = 7'b0111011;
  localparam logic [6:0] OP_IMM32  = 7'b0011011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_FENCE  = 7'b0001111;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_SYSTEM = 7'b1110011;
  localparam logic [6:0] OP_LUI    = 7'b0110111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_NONE   = 7'b0000000;

  localparam logic [6:0] F7_BASE   = 7'b0000000;
  localparam logic [6:0] F7_ALT    = 7'b0100000;
  localparam logic [6:0] F7_MULDIV = 7'b0000001;

  localparam logic [2:0] F3_XOR    = 3'd4;
  localparam logic [11:0] IMM_ONE  = 12'b000000000001;
  localparam logic [WORD_W-1:0] WORD_END = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    FMT_J, FMT_B, FMT_L, FMT_R, FMT_P, FMT_S, FMT_I, FMT_SH, FMT_SY, FMT_U, FMT_E
  } fmt_t;

  typedef struct packed {
    fmt_t       fmt;
    logic [6:0] op;
    logic [2:0] f3;
    logic [6:0] f7;
    logic       swap;
  } dec_t;

  // Encoder outcome for one input transaction.
  typedef struct packed {
    logic [1:0]        count;
    logic [WORD_W-1:0] word0;
    logic [ERR_W-1:0]  err;
    logic [WORD_W-1:0] word1;
  } enc_res_t;

  localparam dec_t DEC_TABLE [NUM_CODES] = '{
    '{FMT_J,  OP_JAL,    3'd0, F7_BASE,   1'b0},
    '{FMT_B,  OP_BRANCH, 3'd0, F7_BASE,   1'b0},
    '{FMT_B,  OP_BRANCH, 3'd1, F7_BASE,   1'b0},
    '{FMT_B,  OP_BRANCH, 3'd4, F7_BASE,   1'b0},
    '{FMT_B,  OP_BRANCH, 3'd4, F7_BASE,   1'b1},
    '{FMT_B,  OP_BRANCH, 3'd5, F7_BASE,   1'b0},
    '{FMT_B,  OP_BRANCH, 3'd5, F7_BASE,   1'b1},
    '{FMT_B,  OP_BRANCH, 3'd6, F7_BASE,   1'b0},
    '{FMT_B,  OP_BRANCH, 3'd6, F7_BASE,   1'b1},
    '{FMT_B,  OP_BRANCH, 3'd7, F7_BASE,   1'b0},
    '{FMT_B,  OP_BRANCH, 3'd7, F7_BASE,   1'b1},
    '{FMT_L,  OP_NONE,   3'd0, F7_BASE,   1'b0},
    '{FMT_R,  OP_REG,    3'd0, F7_BASE,   1'b0},
    '{FMT_R,  OP_REG32,  3'd0, F7_BASE,   1'b0},
    '{FMT_R,  OP_REG,    3'd0, F7_ALT,    1'b0},
    '{FMT_R,  OP_REG32,  3'd0, F7_ALT,    1'b0},
    '{FMT_R,  OP_REG,    3'd0, F7_MULDIV, 1'b0},
    '{FMT_R,  OP_REG,    3'd4, F7_MULDIV, 1'b0},
    '{FMT_R,  OP_REG,    3'd6, F7_MULDIV, 1'b0},
    '{FMT_R,  OP_REG,    3'd1, F7_BASE,   1'b0},
    '{FMT_R,  OP_REG32,  3'd1, F7_BASE,   1'b0},
    '{FMT_R,  OP_REG,    3'd5, F7_BASE,   1'b0},
    '{FMT_R,  OP_REG32,  3'd5, F7_BASE,   1'b0},
    '{FMT_R,  OP_REG,    3'd5, F7_ALT,    1'b0},
    '{FMT_R,  OP_REG32,  3'd5, F7_ALT,    1'b0},
    '{FMT_R,  OP_REG,    3'd7, F7_BASE,   1'b0},
    '{FMT_R,  OP_REG,    3'd6, F7_BASE,   1'b0},
    '{FMT_R,  OP_REG,    3'd4, F7_BASE,   1'b0},
    '{FMT_R,  OP_REG,    3'd2, F7_BASE,   1'b0},
    '{FMT_R,  OP_REG,    3'd3, F7_BASE,   1'b0},
    '{FMT_R,  OP_REG,    3'd2, F7_BASE,   1'b1},
    '{FMT_R,  OP_REG,    3'd3, F7_BASE,   1'b1},
    '{FMT_P,  OP_REG,    3'd2, F7_BASE,   1'b1},
    '{FMT_P,  OP_REG,    3'd2, F7_BASE,   1'b0},
    '{FMT_P,  OP_REG,    3'd3, F7_BASE,   1'b1},
    '{FMT_P,  OP_REG,    3'd3, F7_BASE,   1'b0},
    '{FMT_S,  OP_STORE,  3'd0, F7_BASE,   1'b0},
    '{FMT_S,  OP_STORE,  3'd1, F7_BASE,   1'b0},
    '{FMT_S,  OP_STORE,  3'd2, F7_BASE,   1'b0},
    '{FMT_S,  OP_STORE,  3'd3, F7_BASE,   1'b0},
    '{FMT_I,  OP_LOAD,   3'd0, F7_BASE,   1'b0},
    '{FMT_I,  OP_LOAD,   3'd1, F7_BASE,   1'b0},
    '{FMT_I,  OP_LOAD,   3'd2, F7_BASE,   1'b0},
    '{FMT_I,  OP_LOAD,   3'd3, F7_BASE,   1'b0},
    '{FMT_I,  OP_LOAD,   3'd4, F7_BASE,   1'b0},
    '{FMT_I,  OP_LOAD,   3'd5, F7_BASE,   1'b0},
    '{FMT_I,  OP_LOAD,   3'd6, F7_BASE,   1'b0},
    '{FMT_I,  OP_FENCE,  3'd0, F7_BASE,   1'b0},
    '{FMT_I,  OP_FENCE,  3'd1, F7_BASE,   1'b0},
    '{FMT_I,  OP_IMM,    3'd0, F7_BASE,   1'b0},
    '{FMT_I,  OP_IMM32,  3'd0, F7_BASE,   1'b0},
    '{FMT_I,  OP_IMM,    3'd7, F7_BASE,   1'b0},
    '{FMT_I,  OP_IMM,    3'd6, F7_BASE,   1'b0},
    '{FMT_I,  OP_IMM,    3'd4, F7_BASE,   1'b0},
    '{FMT_SH, OP_IMM,    3'd1, F7_BASE,   1'b0},
    '{FMT_SH, OP_IMM,    3'd5, F7_BASE,   1'b0},
    '{FMT_SH, OP_IMM,    3'd5, F7_ALT,    1'b0},
    '{FMT_SH, OP_IMM32,  3'd1, F7_BASE,   1'b0},
    '{FMT_SH, OP_IMM32,  3'd5, F7_BASE,   1'b0},
    '{FMT_SH, OP_IMM32,  3'd5, F7_ALT,    1'b0},
    '{FMT_I,  OP_IMM,    3'd2, F7_BASE,   1'b0},
    '{FMT_I,  OP_IMM,    3'd3, F7_BASE,   1'b0},
    '{FMT_I,  OP_JALR,   3'd0, F7_BASE,   1'b0},
    '{FMT_SY, OP_SYSTEM, 3'd0, 7'd0,      1'b0},
    '{FMT_SY, OP_SYSTEM, 3'd0, 7'd1,      1'b0},
    '{FMT_I,  OP_SYSTEM, 3'd1, F7_BASE,   1'b0},
    '{FMT_I,  OP_SYSTEM, 3'd2, F7_BASE,   1'b0},
    '{FMT_I,  OP_SYSTEM, 3'd3, F7_BASE,   1'b0},
    '{FMT_I,  OP_SYSTEM, 3'd5, F7_BASE,   1'b0},
    '{FMT_I,  OP_SYSTEM, 3'd6, F7_BASE,   1'b0},
    '{FMT_I,  OP_SYSTEM, 3'd7, F7_BASE,   1'b0},
    '{FMT_U,  OP_LUI,    3'd0, F7_BASE,   1'b0},
    '{FMT_U,  OP_AUIPC,  3'd0, F7_BASE,   1'b0},
    '{FMT_E,  OP_NONE,   3'd0, F7_BASE,   1'b0}
  };

endpackage

FILE: sv/rie_enc.sv
// Combinational instruction encoder: decode lookup, range checks and field packing.
module rie_enc (
  input  logic [rie_pkg::CODE_W-1:0]  code,
  input  logic [rie_pkg::REG_W-1:0]   rd,
  input  logic [rie_pkg::REG_W-1:0]   ra,
  input  logic [rie_pkg::REG_W-1:0]   rb,
  input  logic [rie_pkg::IMM_W-1:0]   imm,
  input  logic [rie_pkg::ADDR_W-1:0]  tgt,
  input  logic [rie_pkg::ADDR_W-1:0]  pc,
  output rie_pkg::enc_res_t           res
);

  rie_pkg::dec_t             dec;
  logic                      known;
  logic signed [rie_pkg::ADDR_W:0] off;
  logic                      jal_ok;
  logic                      br_ok;
  logic                      imm12_ok;
  logic [rie_pkg::REG_W-1:0] f1;
  logic [rie_pkg::REG_W-1:0] f2;
  logic [rie_pkg::WORD_W-1:0] word;
  logic [rie_pkg::ERR_W-1:0] err;

  assign known = (code < rie_pkg::CODE_W'(rie_pkg::NUM_CODES));
  assign dec   = rie_pkg::DEC_TABLE[code];

  // Offset is taken without wrap, so one extra bit holds its sign.
  assign off = $signed({1'b0, tgt}) - $signed({1'b0, pc});

  // An offset or immediate fits when all bits above the field agree with its sign.
  assign jal_ok   = (&off[rie_pkg::ADDR_W:20]) || !(|off[rie_pkg::ADDR_W:20]);
  assign br_ok    = (&off[rie_pkg::ADDR_W:12]) || !(|off[rie_pkg::ADDR_W:12]);
  assign imm12_ok = (&imm[rie_pkg::IMM_W-1:11]) || !(|imm[rie_pkg::IMM_W-1:11]);

  // Swapped compares exchange the two source register fields.
  assign f2 = dec.swap ? ra : rb;
  assign f1 = dec.swap ? rb : ra;

  always_comb begin
    word      = '0;
    err       = rie_pkg::ERR_OK;
    res.count = 2'd1;
    res.word1 = {rie_pkg::IMM_ONE, rd, rie_pkg::F3_XOR, rd, rie_pkg::OP_IMM};
    unique case (dec.fmt)
      rie_pkg::FMT_J: begin
        if (!jal_ok) begin
          err = rie_pkg::ERR_RANGE;
        end else begin
          word = {off[20], off[10:1], off[11], off[19:12], rd, dec.op};
        end
      end
      rie_pkg::FMT_B: begin
        if (!br_ok) begin
          err = rie_pkg::ERR_RANGE;
        end else begin
          word = {off[12], off[10:5], f2, f1, dec.f3, off[4:1], off[11], dec.op};
        end
      end
      rie_pkg::FMT_L: begin
        res.count = 2'd0;
      end
      rie_pkg::FMT_R: begin
        word = {dec.f7, f2, f1, dec.f3, rd, dec.op};
      end
      rie_pkg::FMT_P: begin
        // Compare into rd, then invert it with xori rd, rd, 1.
        res.count = 2'd2;
        word = {rie_pkg::F7_BASE, f2, f1, dec.f3, rd, dec.op};
      end
      rie_pkg::FMT_S: begin
        if (!imm12_ok) begin
          err = rie_pkg::ERR_RANGE;
        end else begin
          word = {imm[11:5], rb, ra, dec.f3, imm[4:0], dec.op};
        end
      end
      rie_pkg::FMT_I: begin
        if (!imm12_ok) begin
          err = rie_pkg::ERR_RANGE;
        end else begin
          word = {imm[11:0], ra, dec.f3, rd, dec.op};
        end
      end
      rie_pkg::FMT_SH: begin
        if (imm[rie_pkg::IMM_W-1]) begin
          err = rie_pkg::ERR_NEG_SHIFT;
        end else if (|imm[rie_pkg::IMM_W-2:5]) begin
          err = rie_pkg::ERR_RANGE;
        end else begin
          word = {dec.f7, imm[4:0], ra, dec.f3, rd, dec.op};
        end
      end
      rie_pkg::FMT_SY: begin
        word = {5'd0, dec.f7, ra, dec.f3, rd, dec.op};
      end
      rie_pkg::FMT_U: begin
        word = {imm, rd, dec.op};
      end
      rie_pkg::FMT_E: begin
        word = rie_pkg::WORD_END;
      end
      default: begin
        err = rie_pkg::ERR_UNKNOWN;
      end
    endcase
    if (!known) begin
      res.count = 2'd1;
      err       = rie_pkg::ERR_UNKNOWN;
      word      = '0;
    end
    res.err   = err;
    res.word0 = word;
  end

endmodule

FILE: sv/riscv_instruction_encoder_core.sv
// Top level of the instruction encoder: input register, program counter and result staging.
// The encoder takes one instruction transaction per cycle on the item channel unless
// item_stall is high, and returns encoded 32-bit words on the word channel, each tagged
// with the address it occupies. An accepted transaction sits in an input register while
// the encoder packs it against the current program counter; the result then moves into an
// output register. Ordinary instructions, the end marker and every error case give one word
// each and go back to back unless the word port stalls. The set-less-or-equal and
// set-greater-or-equal pseudo-ops give two words; the second waits in a holding register
// and goes out, at the pace the word port sets, before the next instruction is encoded.
// A label marker gives no word and leaves the program counter alone. The program counter
// starts at zero after reset, advances by four per word (also for error words) and wraps
// at 2^32. A word with a nonzero error code always carries an all-zero machine word.
`include "riscv_instruction_encoder_core_defines.svh"

module riscv_instruction_encoder_core (
  input  logic                         clk,
  input  logic                         rst,
  // Item channel.
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic [rie_pkg::CODE_W-1:0]   req_type,
  input  logic [rie_pkg::REG_W-1:0]    dest_reg,
  input  logic [rie_pkg::REG_W-1:0]    src_reg_a,
  input  logic [rie_pkg::REG_W-1:0]    src_reg_b,
  input  logic signed [rie_pkg::IMM_W-1:0] immediate,
  input  logic [rie_pkg::ADDR_W-1:0]   target_address,
  // Word channel.
  output logic                         word_valid,
  input  logic                         word_stall,
  output logic [rie_pkg::ADDR_W-1:0]   word_address,
  output logic [rie_pkg::WORD_W-1:0]   machine_word,
  output logic [rie_pkg::ERR_W-1:0]    error_code,
  output logic                         last_word
);

  // Input register.
  logic                        s1_valid;
  logic [rie_pkg::CODE_W-1:0]  s1_code;
  logic [rie_pkg::REG_W-1:0]   s1_rd;
  logic [rie_pkg::REG_W-1:0]   s1_ra;
  logic [rie_pkg::REG_W-1:0]   s1_rb;
  logic [rie_pkg::IMM_W-1:0]   s1_imm;
  logic [rie_pkg::ADDR_W-1:0]  s1_tgt;

  // Program counter.
  logic [rie_pkg::ADDR_W-1:0]  pc;
  logic [rie_pkg::ADDR_W-1:0]  pc_next;
  logic [rie_pkg::ADDR_W-1:0]  pc_step;

  // Holding register for the second word of a two-word expansion.
  logic                        hold_valid;
  logic [rie_pkg::ADDR_W-1:0]  hold_addr;
  logic [rie_pkg::WORD_W-1:0]  hold_word;

  rie_pkg::enc_res_t           enc;
  logic                        item_take;
  logic                        out_free;
  logic                        s1_consume;
  logic                        hold_drain;

  rie_enc u_enc (
    .code (s1_code),
    .rd   (s1_rd),
    .ra   (s1_ra),
    .rb   (s1_rb),
    .imm  (s1_imm),
    .tgt  (s1_tgt),
    .pc   (pc),
    .res  (enc)
  );

  // The output register frees up when it is empty or its transaction is taken this cycle.
  assign out_free   = !word_valid || !word_stall;
  // A pending second word goes out before the next instruction is encoded.
  assign hold_drain = out_free && hold_valid;
  assign s1_consume = out_free && !hold_valid && s1_valid;
  // The input register refills in the same cycle that it drains.
  assign item_stall = s1_valid && !s1_consume;
  assign item_take  = item_valid && !item_stall;

  always_comb begin
    unique case (enc.count)
      2'd2:    pc_step = rie_pkg::WORD_BYTES + rie_pkg::WORD_BYTES;
      2'd1:    pc_step = rie_pkg::WORD_BYTES;
      default: pc_step = '0;
    endcase
    pc_next = s1_consume ? (pc + pc_step) : pc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_take) begin
      s1_valid <= 1'b1;
    end else if (s1_consume) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      s1_code <= req_type;
      s1_rd   <= dest_reg;
      s1_ra   <= src_reg_a;
      s1_rb   <= src_reg_b;
      s1_imm  <= immediate;
      s1_tgt  <= target_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= rie_pkg::PC_RESET;
    end else begin
      pc <= pc_next;
    end
  end

  // Control for the output and holding registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
      hold_valid <= 1'b0;
    end else if (hold_drain) begin
      word_valid <= 1'b1;
      hold_valid <= 1'b0;
    end else if (out_free) begin
      word_valid <= s1_consume && (enc.count != 2'd0);
      hold_valid <= s1_consume && (enc.count == 2'd2);
    end
  end

  // Payload of the output and holding registers.
  always_ff @(posedge clk) begin
    if (hold_drain) begin
      word_address <= hold_addr;
      machine_word <= hold_word;
      error_code   <= rie_pkg::ERR_OK;
      last_word    <= 1'b1;
    end else if (s1_consume) begin
      word_address <= pc;
      machine_word <= enc.word0;
      error_code   <= enc.err;
      last_word    <= (enc.count != 2'd2);
      hold_addr    <= pc + rie_pkg::WORD_BYTES;
      hold_word    <= enc.word1;
    end
  end

  // A pending second word always sits behind a first word that has not gone out yet.
  `RIE_ASSERT_IMP(a_hold_behind_out, clk, rst, hold_valid, word_valid)
  // An error result never carries a nonzero machine word.
  `RIE_ASSERT_IMP(a_err_word_zero, clk, rst, word_valid && (error_code != rie_pkg::ERR_OK), machine_word == '0)
  // The second word of an expansion ends its instruction and carries no error.
  `RIE_ASSERT_NXT(a_hold_is_last, clk, rst, hold_drain, word_valid && last_word && (error_code == rie_pkg::ERR_OK))
  // The counter moves only when an instruction leaves the input register.
  `RIE_ASSERT_NXT(a_pc_hold, clk, rst, !s1_consume, pc == $past(pc))
  // The input side never stalls while the input register is empty.
  `RIE_ASSERT_IMP(a_no_idle_stall, clk, rst, !s1_valid, !item_stall)

endmodule
